FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/gnfs_pkg.sv
// Types and constants of the GPS NMEA/UBX frame splitter
package gnfs_pkg;

   localparam int CNT_W = 7;
   localparam int BUF_W = 2;

   localparam logic [CNT_W-1:0] NMEA_CAPACITY = 7'd100;
   localparam logic [CNT_W-1:0] UBX_CAPACITY  = 7'd50;
   localparam logic [BUF_W-1:0] NMEA_SLOTS    = 2'd3;

   localparam logic [7:0] BYTE_DOLLAR   = 8'h24;
   localparam logic [7:0] BYTE_STAR     = 8'h2A;
   localparam logic [7:0] BYTE_UBX_SYNC = 8'hB5;

   localparam logic [BUF_W-1:0] UBX_BUFFER_ID = 2'd3;

   localparam logic DONE_NMEA = 1'b0;
   localparam logic DONE_UBX  = 1'b1;

   typedef enum logic [1:0] {
      PH_NONE = 2'd0,
      PH_STAR = 2'd1,
      PH_ONE  = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   typedef struct packed {
      logic             wr_valid;
      logic [BUF_W-1:0] wr_buffer;
      logic [CNT_W-1:0] wr_index;
      logic [7:0]       wr_data;
      logic             done_valid;
      logic             done_type;
      logic [CNT_W-1:0] done_length;
      logic [BUF_W-1:0] done_buffer;
      logic             overflow;
   } result_type;

   typedef struct packed {
      logic nmea_active;
      logic ubx_active;
   } status_type;

endpackage

FILE: hw/rtl/gps_nmea_ubx_frame_splitter.sv
// Top level of the GPS NMEA/UBX frame splitter
// One received byte per item, one result per byte. The block takes a byte in
// every clock while req_stall is low; an accepted byte is held in the input
// register, then passes through the frame tracking logic into the result
// register, from which its result is presented. While a result waits on a
// stalled output the input register takes one more byte and then raises
// req_stall until the result leaves.
// NMEA sentences fill slots 0 to 2 in turn, UBX frames buffer 3; bytes beyond
// a buffer's capacity are dropped and flagged with overflow.
`include "assert_macros.svh"

module gps_nmea_ubx_frame_splitter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_wr_valid,
   output logic [gnfs_pkg::BUF_W-1:0]    rsp_wr_buffer,
   output logic [gnfs_pkg::CNT_W-1:0]    rsp_wr_index,
   output logic [7:0]                    rsp_wr_data,
   output logic                          rsp_done_valid,
   output logic                          rsp_done_type,
   output logic [gnfs_pkg::CNT_W-1:0]    rsp_done_length,
   output logic [gnfs_pkg::BUF_W-1:0]    rsp_done_buffer,
   output logic                          rsp_overflow
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff, in_byte_in;
   logic                  out_valid_ff, out_valid_in;
   gnfs_pkg::result_type  res_ff, res_in;
   gnfs_pkg::result_type  core_res;
   gnfs_pkg::status_type  core_status;
   logic                  accept;
   logic                  move;
   logic                  both_open;
   logic                  wr_in_range;
   logic                  ubx_done_ok;

   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !move);
   assign in_byte_in   = accept ? req_rx_byte : in_byte_ff;
   assign out_valid_in = move || (out_valid_ff && rsp_stall);
   assign res_in       = move ? core_res : res_ff;

   gnfs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (move),
      .rx_byte (in_byte_ff),
      .result  (core_res),
      .status  (core_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      res_ff     <= res_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_wr_valid    = res_ff.wr_valid;
   assign rsp_wr_buffer   = res_ff.wr_buffer;
   assign rsp_wr_index    = res_ff.wr_index;
   assign rsp_wr_data     = res_ff.wr_data;
   assign rsp_done_valid  = res_ff.done_valid;
   assign rsp_done_type   = res_ff.done_type;
   assign rsp_done_length = res_ff.done_length;
   assign rsp_done_buffer = res_ff.done_buffer;
   assign rsp_overflow    = res_ff.overflow;

   assign both_open   = core_status.nmea_active && core_status.ubx_active;
   assign wr_in_range = (res_ff.wr_buffer == gnfs_pkg::UBX_BUFFER_ID) ?
                        (res_ff.wr_index < gnfs_pkg::UBX_CAPACITY) :
                        (res_ff.wr_index < gnfs_pkg::NMEA_CAPACITY);
   assign ubx_done_ok = !(res_ff.done_valid && res_ff.done_type == gnfs_pkg::DONE_UBX) ||
                        (res_ff.done_buffer == gnfs_pkg::UBX_BUFFER_ID);

   `ASSERT_ALWAYS(a_modes_exclusive, clock, reset, !both_open)
   `ASSERT_ALWAYS(a_index_in_range, clock, reset, !(out_valid_ff && res_ff.wr_valid) || wr_in_range)
   `ASSERT_ALWAYS(a_ubx_done_buffer, clock, reset, !out_valid_ff || ubx_done_ok)
   `ASSERT_NEXT(a_blocked_item_kept, clock, reset, in_valid_ff && !move, in_valid_ff && in_byte_ff == $past(in_byte_ff))

endmodule

FILE: hw/rtl/gnfs_core.sv
// Frame tracking state and per-byte result logic
module gnfs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            rx_byte,
   output gnfs_pkg::result_type  result,
   output gnfs_pkg::status_type  status
);

   logic                          nmea_active_ff, nmea_active_in;
   logic                          ubx_active_ff, ubx_active_in;
   logic [gnfs_pkg::CNT_W-1:0]    byte_count_ff, byte_count_in;
   gnfs_pkg::phase_type           phase_ff, phase_in;
   logic [gnfs_pkg::BUF_W-1:0]    slot_ff, slot_in;

   logic                          put_en;
   logic [gnfs_pkg::BUF_W-1:0]    put_buf;
   logic [gnfs_pkg::CNT_W-1:0]    put_cap;
   logic [gnfs_pkg::CNT_W-1:0]    put_base;
   logic                          done_nmea;
   logic                          done_ubx;
   logic [gnfs_pkg::BUF_W-1:0]    cur_slot;

   always_comb begin
      nmea_active_in = nmea_active_ff;
      ubx_active_in  = ubx_active_ff;
      byte_count_in  = byte_count_ff;
      phase_in       = phase_ff;
      cur_slot       = (slot_ff >= gnfs_pkg::NMEA_SLOTS) ? '0 : slot_ff;
      slot_in        = cur_slot;
      put_en         = 1'b0;
      put_buf        = cur_slot;
      put_cap        = gnfs_pkg::NMEA_CAPACITY;
      put_base       = byte_count_ff;
      done_nmea      = 1'b0;
      done_ubx       = 1'b0;
      result         = '0;

      priority if (nmea_active_ff) begin
         put_en = 1'b1;
         priority if (rx_byte == gnfs_pkg::BYTE_STAR) begin
            phase_in = gnfs_pkg::PH_STAR;
         end else if (phase_ff == gnfs_pkg::PH_STAR) begin
            phase_in = gnfs_pkg::PH_ONE;
         end else if (phase_ff == gnfs_pkg::PH_ONE) begin
            nmea_active_in = 1'b0;
            phase_in       = gnfs_pkg::PH_DONE;
            done_nmea      = 1'b1;
            slot_in        = (cur_slot == gnfs_pkg::NMEA_SLOTS - 2'd1) ? '0 : cur_slot + 2'd1;
         end else begin
            phase_in = phase_ff;
         end
      end else if (rx_byte == gnfs_pkg::BYTE_DOLLAR) begin
         done_ubx       = ubx_active_ff;
         ubx_active_in  = 1'b0;
         phase_in       = gnfs_pkg::PH_NONE;
         nmea_active_in = 1'b1;
         put_en         = 1'b1;
         put_base       = '0;
      end else if (rx_byte == gnfs_pkg::BYTE_UBX_SYNC) begin
         ubx_active_in = 1'b1;
         put_en        = 1'b1;
         put_buf       = gnfs_pkg::UBX_BUFFER_ID;
         put_cap       = gnfs_pkg::UBX_CAPACITY;
         put_base      = '0;
      end else if (ubx_active_ff) begin
         put_en   = 1'b1;
         put_buf  = gnfs_pkg::UBX_BUFFER_ID;
         put_cap  = gnfs_pkg::UBX_CAPACITY;
      end else begin
         put_en = 1'b0;
      end

      if (put_en) begin
         if (put_base < put_cap) begin
            result.wr_valid  = 1'b1;
            result.wr_buffer = put_buf;
            result.wr_index  = put_base;
            result.wr_data   = rx_byte;
            byte_count_in    = put_base + 7'd1;
         end else begin
            result.overflow = 1'b1;
            byte_count_in   = put_cap;
         end
      end

      // UBX length is taken before the '$' restarts the count
      if (done_ubx) begin
         result.done_valid  = 1'b1;
         result.done_type   = gnfs_pkg::DONE_UBX;
         result.done_length = byte_count_ff;
         result.done_buffer = gnfs_pkg::UBX_BUFFER_ID;
      end else if (done_nmea) begin
         result.done_valid  = 1'b1;
         result.done_type   = gnfs_pkg::DONE_NMEA;
         result.done_length = byte_count_in;
         result.done_buffer = cur_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nmea_active_ff <= 1'b0;
         ubx_active_ff  <= 1'b0;
         byte_count_ff  <= '0;
         phase_ff       <= gnfs_pkg::PH_NONE;
         slot_ff        <= '0;
      end else if (step_en) begin
         nmea_active_ff <= nmea_active_in;
         ubx_active_ff  <= ubx_active_in;
         byte_count_ff  <= byte_count_in;
         phase_ff       <= phase_in;
         slot_ff        <= slot_in;
      end
   end

   assign status.nmea_active = nmea_active_ff;
   assign status.ubx_active  = ubx_active_ff;

endmodule
